// ===== rtl/core/laser_zone_obstacle_detect_unit_macros.svh =====
// Assertion macros shared by the obstacle detector RTL.
`ifndef LASER_ZONE_OBSTACLE_DETECT_UNIT_MACROS_SVH
`define LASER_ZONE_OBSTACLE_DETECT_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LZOD_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define LZOD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/lzod_pkg.sv =====
// Shared types, constants and sector geometry of the obstacle detector.
package lzod_pkg;

    localparam int SCAN_POINTS = 360;
    localparam int SECTORS     = 5;

    localparam int IDX_W       = 10;
    localparam int OFF_W       = IDX_W + 1;
    localparam int RANGE_W     = 16;
    localparam int CNT_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 72;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int SEC_FRONT       = 0;
    localparam int SEC_FRONT_LEFT  = 1;
    localparam int SEC_FRONT_RIGHT = 2;
    localparam int SEC_LEFT        = 3;
    localparam int SEC_RIGHT       = 4;

    localparam logic [RANGE_W-1:0] NO_RETURN = {RANGE_W{1'b1}};

    // First index of each sector: (centre - half width) mod SCAN_POINTS.
    localparam logic [IDX_W-1:0] SEC_START [SECTORS] = '{
        IDX_W'((0   % SCAN_POINTS + SCAN_POINTS - 30 % SCAN_POINTS) % SCAN_POINTS),
        IDX_W'((45  % SCAN_POINTS + SCAN_POINTS - 20 % SCAN_POINTS) % SCAN_POINTS),
        IDX_W'((315 % SCAN_POINTS + SCAN_POINTS - 20 % SCAN_POINTS) % SCAN_POINTS),
        IDX_W'((90  % SCAN_POINTS + SCAN_POINTS - 30 % SCAN_POINTS) % SCAN_POINTS),
        IDX_W'((270 % SCAN_POINTS + SCAN_POINTS - 30 % SCAN_POINTS) % SCAN_POINTS)
    };

    // Full width of each sector: twice the half width.
    localparam logic [OFF_W-1:0] SEC_SPAN [SECTORS] = '{
        OFF_W'(2 * 30), OFF_W'(2 * 20), OFF_W'(2 * 20), OFF_W'(2 * 30), OFF_W'(2 * 30)
    };

    localparam logic [RANGE_W-1:0] RANGE_MIN_RST     = RANGE_W'(0);
    localparam logic [RANGE_W-1:0] RANGE_MAX_RST     = RANGE_W'(65535);
    localparam logic [RANGE_W-1:0] OBSTACLE_DIST_RST = RANGE_W'(500);
    localparam logic [RANGE_W-1:0] CLEAR_DIST_RST    = RANGE_W'(750);
    localparam logic [CNT_W-1:0]   HYST_ON_RST       = CNT_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_MIN     = 3'd0,
        CFG_RANGE_MAX     = 3'd1,
        CFG_OBSTACLE_DIST = 3'd2,
        CFG_CLEAR_DIST    = 3'd3,
        CFG_HYST_ON       = 3'd4
    } lzod_cfg_idx_t;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_CLEAR  = 1'b1
    } lzod_action_t;

    typedef struct packed {
        logic [RANGE_W-1:0] rng_floor;
        logic [RANGE_W-1:0] rng_ceil;
        logic [RANGE_W-1:0] obst_limit;
        logic [RANGE_W-1:0] clear_dist;
        logic [CNT_W-1:0]   hyst_on;
    } lzod_cfg_t;

    // Classified request handed from the front end to the back end.
    typedef struct packed {
        logic               clear;
        logic               last;
        logic [SECTORS-1:0] hit;
        logic [RANGE_W-1:0] range;
    } lzod_rec_t;

    typedef struct packed {
        logic              valid;
        logic              full;
        logic [QCNT_W-1:0] count;
    } lzod_qstat_t;

endpackage

// ===== rtl/core/lzod_front.sv =====
// Front end: accept input requests, validate the sample and find its sectors.
module lzod_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lzod_pkg::lzod_cfg_t       cfg,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [lzod_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                      s_tuser,
    input  logic                      s_tlast,
    output logic                      rec_valid,
    output lzod_pkg::lzod_rec_t       rec,
    input  logic                      push_ok
);

    logic                          valid_reg;
    logic                          valid_next;
    lzod_pkg::lzod_rec_t           rec_reg;
    lzod_pkg::lzod_rec_t           rec_next;
    logic [lzod_pkg::IDX_W-1:0]    idx;
    logic [lzod_pkg::RANGE_W-1:0]  rng;
    logic                          finite;
    logic                          sample_ok;
    logic [lzod_pkg::OFF_W-1:0]    off_sum [lzod_pkg::SECTORS];
    logic [lzod_pkg::OFF_W-1:0]    off     [lzod_pkg::SECTORS];
    logic                          accept;
    logic                          push;

    assign idx    = s_tdata[lzod_pkg::IDX_W-1:0];
    assign rng    = s_tdata[lzod_pkg::IDX_W +: lzod_pkg::RANGE_W];
    assign finite = s_tdata[lzod_pkg::IDX_W + lzod_pkg::RANGE_W];

    assign push     = valid_reg && push_ok;
    assign s_tready = !valid_reg || push_ok;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        sample_ok = finite && (rng > cfg.rng_floor) && (rng < cfg.rng_ceil) &&
                    ({1'b0, idx} < lzod_pkg::OFF_W'(lzod_pkg::SCAN_POINTS));
        for (int s = 0; s < lzod_pkg::SECTORS; s++)
        begin
            // Offset from sector start, wrapped once around the scan.
            off_sum[s] = {1'b0, idx} + lzod_pkg::OFF_W'(lzod_pkg::SCAN_POINTS)
                         - {1'b0, lzod_pkg::SEC_START[s]};
            off[s] = (off_sum[s] >= lzod_pkg::OFF_W'(lzod_pkg::SCAN_POINTS))
                     ? off_sum[s] - lzod_pkg::OFF_W'(lzod_pkg::SCAN_POINTS)
                     : off_sum[s];
            rec_next.hit[s] = sample_ok && (off[s] <= lzod_pkg::SEC_SPAN[s]);
        end
        rec_next.clear = (lzod_pkg::lzod_action_t'(s_tuser) == lzod_pkg::ACT_CLEAR);
        rec_next.last  = s_tlast;
        rec_next.range = rng;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec_valid = valid_reg;
    assign rec       = rec_reg;

endmodule

// ===== rtl/core/lzod_queue.sv =====
// Short request queue between the front end and the back end.
module lzod_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lzod_pkg::lzod_rec_t   push_rec,
    input  logic                  pop,
    output lzod_pkg::lzod_rec_t   pop_rec,
    output lzod_pkg::lzod_qstat_t stat
);

    lzod_pkg::lzod_rec_t           mem [lzod_pkg::QUEUE_DEPTH];
    logic [lzod_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [lzod_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [lzod_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [lzod_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [lzod_pkg::QCNT_W-1:0]   count_reg;
    logic [lzod_pkg::QCNT_W-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    assign pop_rec    = mem[rd_ptr_reg];
    assign stat.valid = (count_reg != '0);
    assign stat.full  = (count_reg == lzod_pkg::QCNT_W'(lzod_pkg::QUEUE_DEPTH));
    assign stat.count = count_reg;

endmodule

// ===== rtl/core/lzod_back.sv =====
// Back end: fold samples into sector minima, close scans, handle clears and hold the result.
module lzod_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lzod_pkg::lzod_cfg_t       cfg,
    input  logic                      rec_valid,
    input  lzod_pkg::lzod_rec_t       rec,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [lzod_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [lzod_pkg::RANGE_W-1:0]  min_reg  [lzod_pkg::SECTORS];
    logic [lzod_pkg::RANGE_W-1:0]  min_next [lzod_pkg::SECTORS];
    logic [lzod_pkg::RANGE_W-1:0]  merged   [lzod_pkg::SECTORS];
    logic [lzod_pkg::CNT_W-1:0]    cnt_reg;
    logic [lzod_pkg::CNT_W-1:0]    cnt_next;
    logic [lzod_pkg::CNT_W-1:0]    cnt_scan;
    logic [lzod_pkg::CNT_W:0]      cnt_up;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [lzod_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [lzod_pkg::M_TDATA_W-1:0] out_data_next;
    logic [lzod_pkg::RANGE_W-1:0]  side_min;
    logic [lzod_pkg::RANGE_W-1:0]  nearest;
    logic                          emit;

    assign pop  = rec_valid && (!out_valid_reg || m_tready);
    assign emit = pop && !rec.clear && rec.last;

    always_comb
    begin
        for (int s = 0; s < lzod_pkg::SECTORS; s++)
        begin
            merged[s] = (rec.hit[s] && (rec.range < min_reg[s])) ? rec.range : min_reg[s];
        end
        side_min = (merged[lzod_pkg::SEC_FRONT_LEFT] < merged[lzod_pkg::SEC_FRONT_RIGHT])
                   ? merged[lzod_pkg::SEC_FRONT_LEFT] : merged[lzod_pkg::SEC_FRONT_RIGHT];
        nearest  = (merged[lzod_pkg::SEC_FRONT] < side_min)
                   ? merged[lzod_pkg::SEC_FRONT] : side_min;

        // Saturate at the ceiling on the way up, floor at zero on the way down.
        cnt_up = {1'b0, cnt_reg} + 1'b1;
        if (nearest < cfg.obst_limit)
        begin
            cnt_scan = (cnt_up < {1'b0, cfg.hyst_on}) ? cnt_up[lzod_pkg::CNT_W-1:0]
                                                      : cfg.hyst_on;
        end
        else if (cnt_reg != '0)
        begin
            cnt_scan = cnt_reg - 1'b1;
        end
        else
        begin
            cnt_scan = cnt_reg;
        end

        out_data_next = {1'b0,
                         (merged[lzod_pkg::SEC_FRONT] > cfg.clear_dist),
                         (merged[lzod_pkg::SEC_LEFT] > merged[lzod_pkg::SEC_RIGHT]),
                         (cnt_scan >= cfg.hyst_on),
                         cnt_scan,
                         merged[lzod_pkg::SEC_RIGHT],
                         merged[lzod_pkg::SEC_LEFT],
                         nearest,
                         merged[lzod_pkg::SEC_FRONT]};
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        for (int s = 0; s < lzod_pkg::SECTORS; s++)
        begin
            min_next[s] = min_reg[s];
        end
        if (pop)
        begin
            if (rec.clear)
            begin
                cnt_next = '0;
            end
            else if (rec.last)
            begin
                cnt_next = cnt_scan;
                // Re-arm every sector for the next scan.
                for (int s = 0; s < lzod_pkg::SECTORS; s++)
                begin
                    min_next[s] = lzod_pkg::NO_RETURN;
                end
            end
            else
            begin
                for (int s = 0; s < lzod_pkg::SECTORS; s++)
                begin
                    min_next[s] = merged[s];
                end
            end
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < lzod_pkg::SECTORS; s++)
            begin
                min_reg[s] <= lzod_pkg::NO_RETURN;
            end
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int s = 0; s < lzod_pkg::SECTORS; s++)
            begin
                min_reg[s] <= min_next[s];
            end
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/core/laser_zone_obstacle_detect_unit.sv =====
// Top level of the laser zone obstacle detector.
//
//  Channel  Dir  Handshake           Payload
//  s_*      in   s_tvalid/s_tready   range sample or counter clear request
//  m_*      out  m_tvalid/m_tready   scan result, one per closing sample
//  cfg_*    in   cfg_valid/cfg_ready register write (index, data)
//
// One request per cycle sustained while the queue is not full; a sample passes
// the front register, the four-entry queue and the back end, in that order.
// The back end folds one queued request per cycle into the five sector minima
// unless a result waits on m_tready. A stalled m_tready fills the queue before
// s_tready drops. Reset is asynchronous, active low; no clearing pass is needed.
`include "laser_zone_obstacle_detect_unit_macros.svh"

module laser_zone_obstacle_detect_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lzod_pkg::S_TDATA_W-1:0]      s_tdata,   // angle_index, range_mm, range_finite, 0
    input  logic                                s_tuser,   // action
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // front_min_mm, nearest_mm, left_min_mm, right_min_mm, obstacle_count,
    // obstacle, turn_left, front_clear, 0
    output logic [lzod_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lzod_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lzod_pkg::CFG_DATA_W-1:0]     cfg_data
);

    lzod_pkg::lzod_cfg_t   cfg_reg;
    lzod_pkg::lzod_cfg_t   cfg_next;
    logic                  front_valid;
    lzod_pkg::lzod_rec_t   front_rec;
    logic                  push;
    logic                  pop;
    lzod_pkg::lzod_rec_t   queue_rec;
    lzod_pkg::lzod_qstat_t qstat;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (lzod_pkg::lzod_cfg_idx_t'(cfg_index))
                lzod_pkg::CFG_RANGE_MIN:     cfg_next.rng_floor  = cfg_data;
                lzod_pkg::CFG_RANGE_MAX:     cfg_next.rng_ceil   = cfg_data;
                lzod_pkg::CFG_OBSTACLE_DIST: cfg_next.obst_limit = cfg_data;
                lzod_pkg::CFG_CLEAR_DIST:    cfg_next.clear_dist = cfg_data;
                lzod_pkg::CFG_HYST_ON:
                    cfg_next.hyst_on = cfg_data[lzod_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rng_floor  <= lzod_pkg::RANGE_MIN_RST;
            cfg_reg.rng_ceil   <= lzod_pkg::RANGE_MAX_RST;
            cfg_reg.obst_limit <= lzod_pkg::OBSTACLE_DIST_RST;
            cfg_reg.clear_dist <= lzod_pkg::CLEAR_DIST_RST;
            cfg_reg.hyst_on    <= lzod_pkg::HYST_ON_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign push = front_valid && !qstat.full;

    lzod_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .rec_valid (front_valid),
        .rec       (front_rec),
        .push_ok   (!qstat.full)
    );

    lzod_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (front_rec),
        .pop      (pop),
        .pop_rec  (queue_rec),
        .stat     (qstat)
    );

    lzod_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .rec_valid (qstat.valid),
        .rec       (queue_rec),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `LZOD_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, qstat.full, !push)
    `LZOD_ASSERT_IMPL(a_pop_needs_slot, clk, rst_n, pop && m_tvalid, m_tready)
    `LZOD_ASSERT_NEXT(a_full_queue_stays_busy, clk, rst_n, qstat.full && !pop, qstat.full)

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the laser zone obstacle detector: table-driven and random scans.
module tb;
    import lzod_pkg::*;

    localparam int ZONE_CENTER [SECTORS] = '{0, 45, 315, 90, 270};
    localparam int ZONE_HALF [SECTORS]   = '{30, 20, 20, 30, 30};
    localparam int NUM_DIRECTED = 23;
    localparam int NUM_PHASES   = 7;
    localparam int RANDOM_ITEMS = 1525;
    localparam int DRAIN_CYCLES = 16;

    // s_tdata layout, lowest bits last
    typedef struct packed {
        logic [4:0]         pad;
        logic               finite;
        logic [RANGE_W-1:0] range_mm;
        logic [IDX_W-1:0]   angle;
    } sample_word_t;

    // m_tdata layout, lowest bits last
    typedef struct packed {
        logic               pad;
        logic               front_clear;
        logic               turn_left;
        logic               obstacle;
        logic [CNT_W-1:0]   count;
        logic [RANGE_W-1:0] right_min;
        logic [RANGE_W-1:0] left_min;
        logic [RANGE_W-1:0] nearest;
        logic [RANGE_W-1:0] front_min;
    } scan_report_t;

    typedef struct packed {
        lzod_action_t       action;
        logic [IDX_W-1:0]   angle;
        logic [RANGE_W-1:0] range_mm;
        logic               finite;
        logic               last;
    } laser_req_t;

    typedef struct {
        lzod_action_t act;
        int           angle;
        int           range_mm;
        bit           finite;
        bit           last;
        bit           typed;
        int           front;
        int           nearest;
        int           left;
        int           right;
        int           count;
        bit           obstacle;
        bit           turn_left;
        bit           front_clear;
    } directed_row_t;

    typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    // Reset state first; typed rows are the ones whose result is obvious at a glance.
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{ACT_SAMPLE,    0,   100, 0, 1, 1, 65535, 65535, 65535, 65535, 0, 0, 0, 1},
        '{ACT_SAMPLE,    0, 65535, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,    0,     0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE, 1023,   300, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,  359,     1, 1, 1, 1, 1, 1, 65535, 65535, 1, 0, 0, 0},
        '{ACT_SAMPLE,  330,   400, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,   30,   450, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,   31,    10, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,  329,    20, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,   60,  2000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,  120,  3000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,  240,  1500, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,  300,  1400, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,   90, 65534, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE, 1023,     0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,  180,   600, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_CLEAR,  1023, 65535, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,    0,   499, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,    0,   500, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,  181,    17, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,   45,     1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,   45,     1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SAMPLE,   45,     1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    // Last entry is replaced by random values before its phase starts.
    lzod_cfg_t phase_cfg [NUM_PHASES] = '{
        '{16'd0,     16'd65535, 16'd500,   16'd750,   4'd2},
        '{16'd100,   16'd4000,  16'd1000,  16'd2000,  4'd15},
        '{16'd0,     16'd65535, 16'd1200,  16'd900,   4'd1},
        '{16'd65535, 16'd0,     16'd0,     16'd0,     4'd1},
        '{16'd0,     16'd65535, 16'd65535, 16'd65535, 4'd0},
        '{16'd300,   16'd1000,  16'd700,   16'd65534, 4'd4},
        '{16'd0,     16'd0,     16'd0,     16'd0,     4'd0}
    };

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    lzod_cfg_t          cfg_now;
    logic [RANGE_W-1:0] zone_min [SECTORS];
    logic [CNT_W-1:0]   hyst_count;
    scan_report_t       pending_reports [$];
    int                 mismatches = 0;
    int                 items_sent = 0;
    int                 burst_left = 0;
    rx_mode_t           rx_mode    = RX_OPEN;
    int                 rx_tick    = 0;

    laser_zone_obstacle_detect_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    function automatic bit in_zone(int angle, int zone);
        int start;
        int offset;
        start  = (ZONE_CENTER[zone] % SCAN_POINTS + SCAN_POINTS
                  - ZONE_HALF[zone] % SCAN_POINTS) % SCAN_POINTS;
        offset = (angle + SCAN_POINTS - start) % SCAN_POINTS;
        return offset <= 2 * ZONE_HALF[zone];
    endfunction

    // Fold one request into the zone minima; close the scan on a last sample.
    function automatic void fold_request(input laser_req_t req, output bit emits,
                                         output scan_report_t rep);
        logic [RANGE_W-1:0] near_min;
        int                 up;
        emits = 1'b0;
        rep   = '0;
        if (req.action == ACT_CLEAR)
        begin
            hyst_count = '0;
            return;
        end
        if (req.finite && req.range_mm > cfg_now.rng_floor && req.range_mm < cfg_now.rng_ceil
            && req.angle < SCAN_POINTS)
        begin
            for (int z = 0; z < SECTORS; z++)
                if (in_zone(req.angle, z) && req.range_mm < zone_min[z])
                    zone_min[z] = req.range_mm;
        end
        if (!req.last)
            return;
        near_min = zone_min[SEC_FRONT];
        if (zone_min[SEC_FRONT_LEFT] < near_min)
            near_min = zone_min[SEC_FRONT_LEFT];
        if (zone_min[SEC_FRONT_RIGHT] < near_min)
            near_min = zone_min[SEC_FRONT_RIGHT];
        if (near_min < cfg_now.obst_limit)
        begin
            up = hyst_count + 1;
            hyst_count = (up < cfg_now.hyst_on) ? CNT_W'(up) : cfg_now.hyst_on;
        end
        else if (hyst_count > 0)
            hyst_count = hyst_count - 1'b1;
        rep.front_min   = zone_min[SEC_FRONT];
        rep.nearest     = near_min;
        rep.left_min    = zone_min[SEC_LEFT];
        rep.right_min   = zone_min[SEC_RIGHT];
        rep.count       = hyst_count;
        rep.obstacle    = hyst_count >= cfg_now.hyst_on;
        rep.turn_left   = zone_min[SEC_LEFT] > zone_min[SEC_RIGHT];
        rep.front_clear = zone_min[SEC_FRONT] > cfg_now.clear_dist;
        for (int z = 0; z < SECTORS; z++)
            zone_min[z] = NO_RETURN;
        emits = 1'b1;
    endfunction

    task automatic send_request(input laser_req_t req, input bit typed,
                                input scan_report_t want);
        int           gap;
        sample_word_t word;
        scan_report_t predicted;
        bit           emits;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        word          = '0;
        word.angle    = req.angle;
        word.range_mm = req.range_mm;
        word.finite   = req.finite;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= req.action;
        s_tlast  <= req.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        fold_request(req, emits, predicted);
        if (emits)
            pending_reports.insert(pending_reports.size(), typed ? want : predicted);
        items_sent++;
    endtask

    // Drop valid and wait until every report is in and the pipeline has drained.
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input lzod_cfg_idx_t sel, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (sel)
            CFG_RANGE_MIN:     cfg_now.rng_floor  = value;
            CFG_RANGE_MAX:     cfg_now.rng_ceil   = value;
            CFG_OBSTACLE_DIST: cfg_now.obst_limit = value;
            CFG_CLEAR_DIST:    cfg_now.clear_dist = value;
            CFG_HYST_ON:       cfg_now.hyst_on    = value[CNT_W-1:0];
            default:           ;
        endcase
    endtask

    task automatic write_config(input lzod_cfg_t c);
        write_reg(CFG_RANGE_MIN, c.rng_floor);
        write_reg(CFG_RANGE_MAX, c.rng_ceil);
        write_reg(CFG_OBSTACLE_DIST, c.obst_limit);
        write_reg(CFG_CLEAR_DIST, c.clear_dist);
        // upper data bits are don't-care for the 4-bit register
        write_reg(CFG_HYST_ON, {12'($urandom), c.hyst_on});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [IDX_W-1:0] pick_angle();
        int zone;
        int base;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                zone = $urandom_range(0, SECTORS - 1);
                base = ZONE_CENTER[zone] + ($urandom_range(0, 1) ? ZONE_HALF[zone]
                                                                  : -ZONE_HALF[zone]);
                base = base + $urandom_range(0, 2) - 1;
                return IDX_W'((base + 2 * SCAN_POINTS) % SCAN_POINTS);
            end
            3:       return IDX_W'($urandom_range(SCAN_POINTS, 1023));
            default: return IDX_W'($urandom_range(0, SCAN_POINTS - 1));
        endcase
    endfunction

    // Cluster ranges around the thresholds that the current settings care about.
    function automatic logic [RANGE_W-1:0] pick_range();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 3))
                    0:       return 16'd0;
                    1:       return 16'd1;
                    2:       return 16'd65534;
                    default: return 16'd65535;
                endcase
            1, 2:    return RANGE_W'(cfg_now.obst_limit + $urandom_range(0, 8) - 4);
            3:       return RANGE_W'(cfg_now.clear_dist + $urandom_range(0, 8) - 4);
            4:       return RANGE_W'(cfg_now.rng_floor + $urandom_range(0, 4) - 2);
            5:       return RANGE_W'(cfg_now.rng_ceil + $urandom_range(0, 4) - 2);
            6, 7:
                if (cfg_now.rng_ceil > cfg_now.rng_floor + 1)
                    return RANGE_W'($urandom_range(cfg_now.rng_floor + 1, cfg_now.rng_ceil - 1));
                else
                    return RANGE_W'($urandom);
            default: return RANGE_W'($urandom);
        endcase
    endfunction

    // One scan: mostly short random scans, now and then a full sweep or a noisy one.
    task automatic run_scan();
        int         len;
        bit         sweep;
        bit         noisy;
        laser_req_t req;
        sweep = ($urandom_range(0, 29) == 0);
        noisy = ($urandom_range(0, 9) == 0);
        len   = sweep ? SCAN_POINTS : $urandom_range(1, 40);
        for (int k = 0; k < len; k++)
        begin
            req.action   = ACT_SAMPLE;
            req.angle    = sweep ? IDX_W'(k) : pick_angle();
            req.range_mm = pick_range();
            req.finite   = ($urandom_range(0, 9) != 0);
            req.last     = (k == len - 1) || (noisy && $urandom_range(0, 5) == 0);
            if ($urandom_range(0, 39) == 0)
            begin
                req.action = ACT_CLEAR;
                req.last   = ($urandom_range(0, 1) == 1);
            end
            send_request(req, 1'b0, '0);
        end
    endtask

    // Receiver: switch stall behavior between random modes, paced by rx_tick.
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 256 == 0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: m_tready <= ($urandom_range(0, 4) == 0);
            default:  m_tready <= ((rx_tick % 11) > 6);
        endcase
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        scan_report_t got;
        scan_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_reports.size() == 0)
            begin
                $error("scan report with none pending: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("front_min_mm", want.front_min, got.front_min);
                check_field("nearest_mm", want.nearest, got.nearest);
                check_field("left_min_mm", want.left_min, got.left_min);
                check_field("right_min_mm", want.right_min, got.right_min);
                check_field("obstacle_count", want.count, got.count);
                check_field("obstacle", want.obstacle, got.obstacle);
                check_field("turn_left", want.turn_left, got.turn_left);
                check_field("front_clear", want.front_clear, got.front_clear);
            end
        end
    end

    initial
    begin
        laser_req_t   req;
        scan_report_t want;
        int           phase_end;
        cfg_now.rng_floor  = RANGE_MIN_RST;
        cfg_now.rng_ceil   = RANGE_MAX_RST;
        cfg_now.obst_limit = OBSTACLE_DIST_RST;
        cfg_now.clear_dist = CLEAR_DIST_RST;
        cfg_now.hyst_on    = HYST_ON_RST;
        for (int z = 0; z < SECTORS; z++)
            zone_min[z] = NO_RETURN;
        hyst_count = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows run on reset settings before any register is written.
        foreach (directed_rows[i])
        begin
            req.action        = directed_rows[i].act;
            req.angle         = IDX_W'(directed_rows[i].angle);
            req.range_mm      = RANGE_W'(directed_rows[i].range_mm);
            req.finite        = directed_rows[i].finite;
            req.last          = directed_rows[i].last;
            want              = '0;
            want.front_min    = RANGE_W'(directed_rows[i].front);
            want.nearest      = RANGE_W'(directed_rows[i].nearest);
            want.left_min     = RANGE_W'(directed_rows[i].left);
            want.right_min    = RANGE_W'(directed_rows[i].right);
            want.count        = CNT_W'(directed_rows[i].count);
            want.obstacle     = directed_rows[i].obstacle;
            want.turn_left    = directed_rows[i].turn_left;
            want.front_clear  = directed_rows[i].front_clear;
            send_request(req, directed_rows[i].typed, want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            if (p == NUM_PHASES - 1)
            begin
                phase_cfg[p].rng_floor  = RANGE_W'($urandom_range(0, 2000));
                phase_cfg[p].rng_ceil   = RANGE_W'($urandom_range(3000, 65535));
                phase_cfg[p].obst_limit = RANGE_W'($urandom_range(0, 65535));
                phase_cfg[p].clear_dist = RANGE_W'($urandom_range(0, 65535));
                phase_cfg[p].hyst_on    = CNT_W'($urandom_range(0, 15));
            end
            write_config(phase_cfg[p]);
            phase_end = NUM_DIRECTED + (p + 1) * RANDOM_ITEMS / NUM_PHASES;
            while (items_sent < phase_end)
                run_scan();
        end

        settle();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
